FILE: design/bda_pkg.sv
package bda_pkg;

	localparam int          DEF_TABLE_ENTRIES = 64;
	localparam int          DEF_HEADER_BYTES  = 16;
	localparam logic [31:0] DEF_BASE_ADDRESS  = 32'h0001_0000;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REALLOC = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
	localparam logic [1:0] ST_OVERFLOW   = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] size;
		logic [5:0]  handle;
	} req_t;

	typedef struct packed {
		logic [5:0]  result_handle;
		logic [31:0] data_address;
		logic [31:0] previous_address;
		logic [31:0] block_size;
		logic        reused;
		logic [1:0]  status;
	} rsp_t;

	// One descriptor as held in the table memory.
	typedef struct packed {
		logic        free;
		logic [31:0] size;
		logic [31:0] addr;
	} entry_t;

	typedef struct packed {
		logic [31:0] add_a;
		logic [31:0] add_b;
		logic [31:0] cmp_a;
		logic [31:0] cmp_b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        carry;
		logic        equal;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_HDR,
		S_BUMP,
		S_DONE
	} state_t;

endpackage

FILE: design/bda_ram.sv
module bda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/bda_alu.sv
module bda_alu (
	input  bda_pkg::alu_req_t req,
	output bda_pkg::alu_rsp_t rsp
);
	import bda_pkg::*;

	logic [32:0] sum;

	// The carry out of the 33-bit sum marks a result past the 32-bit address space.
	assign sum       = {1'b0, req.add_a} + {1'b0, req.add_b};
	assign rsp.sum   = sum[31:0];
	assign rsp.carry = sum[32];
	assign rsp.equal = (req.cmp_a == req.cmp_b);

endmodule

FILE: design/block_descriptor_allocator.sv
// An allocate scans from entry 0 for a free entry of its size, one table entry read and
// compared per cycle, over at most count entries (count = descriptors held, 64 at most with
// 64 entries); free and reallocate read their entry once, a bad handle or kind goes straight to its result.
// One item is in work at a time; the next is accepted in the cycle after the result enters the
// output register, taken or not.
// Reset clears the descriptor count and sets the bump pointer to BASE_ADDRESS; the table is kept.
module block_descriptor_allocator #(
	parameter int          TABLE_ENTRIES = bda_pkg::DEF_TABLE_ENTRIES,
	parameter int          HEADER_BYTES  = bda_pkg::DEF_HEADER_BYTES,
	parameter logic [31:0] BASE_ADDRESS  = bda_pkg::DEF_BASE_ADDRESS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bda_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bda_pkg::rsp_t out_data
);
	import bda_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int HW    = (CNT_W > 6) ? CNT_W : 6;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [31:0]        next_q, next_d;
	logic [31:0]        base_q, base_d;
	req_t               req_q, req_d;
	rsp_t               rsp_q, rsp_d;
	rsp_t               out_q;
	logic               out_valid_q;
	logic               out_load;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [IDX_W-1:0]   ram_raddr;
	entry_t             ram_wdata;
	entry_t             ent;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	bda_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ent)
	);

	bda_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		next_d    = next_q;
		base_d    = base_q;
		req_d     = req_q;
		rsp_d     = rsp_q;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ent;
		ram_raddr = idx_q;
		alu_req   = '{add_a: next_q, add_b: req_q.size, cmp_a: req_q.size, cmp_b: ent.size};

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_d = in_data;
					rsp_d = '0;
					unique case (in_data.kind) inside
						KIND_ALLOC: begin
							idx_d     = '0;
							ram_raddr = '0;
							state_d   = (count_q == '0) ? S_HDR : S_SCAN;
						end
						KIND_FREE, KIND_REALLOC: begin
							ram_raddr = IDX_W'(in_data.handle);
							if (HW'(in_data.handle) >= HW'(count_q)) begin
								rsp_d.result_handle = in_data.handle;
								rsp_d.status        = ST_BAD_HANDLE;
								state_d             = S_DONE;
							end else begin
								state_d = S_READ;
							end
						end
						default: begin
							rsp_d.status = ST_BAD_HANDLE;
							state_d      = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				// The read data belongs to idx_q; the next entry is fetched meanwhile.
				ram_raddr = idx_q + IDX_W'(1);
				if (ent.free && alu_rsp.equal) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q;
					ram_wdata = '{free: 1'b0, size: ent.size, addr: ent.addr};
					rsp_d     = '{result_handle: 6'(idx_q), data_address: ent.addr,
						previous_address: '0, block_size: ent.size, reused: 1'b1,
						status: ST_OK};
					state_d   = S_DONE;
				end else if ((CNT_W'(idx_q) + CNT_W'(1)) == count_q) begin
					state_d = S_HDR;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_READ: begin
				ram_waddr = IDX_W'(req_q.handle);
				if (req_q.kind == KIND_FREE) begin
					ram_we    = 1'b1;
					ram_wdata = '{free: 1'b1, size: ent.size, addr: ent.addr};
					rsp_d     = '{result_handle: req_q.handle, data_address: ent.addr,
						previous_address: '0, block_size: ent.size, reused: 1'b0,
						status: ST_OK};
				end else if (alu_rsp.carry) begin
					rsp_d.result_handle = req_q.handle;
					rsp_d.status        = ST_OVERFLOW;
				end else begin
					// A moved entry keeps its free mark.
					ram_we    = 1'b1;
					ram_wdata = '{free: ent.free, size: req_q.size, addr: next_q};
					next_d    = alu_rsp.sum;
					rsp_d     = '{result_handle: req_q.handle, data_address: next_q,
						previous_address: ent.addr, block_size: req_q.size, reused: 1'b0,
						status: ST_OK};
				end
				state_d = S_DONE;
			end
			S_HDR: begin
				alu_req.add_b = 32'(HEADER_BYTES);
				if (count_q == CNT_W'(TABLE_ENTRIES)) begin
					rsp_d.status = ST_FULL;
					state_d      = S_DONE;
				end else if (alu_rsp.carry) begin
					rsp_d.status = ST_OVERFLOW;
					state_d      = S_DONE;
				end else begin
					base_d  = alu_rsp.sum;
					state_d = S_BUMP;
				end
			end
			S_BUMP: begin
				alu_req.add_a = base_q;
				if (alu_rsp.carry) begin
					rsp_d.status = ST_OVERFLOW;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IDX_W-1:0];
					ram_wdata = '{free: 1'b0, size: req_q.size, addr: base_q};
					count_d   = count_q + CNT_W'(1);
					next_d    = alu_rsp.sum;
					rsp_d     = '{result_handle: 6'(count_q), data_address: base_q,
						previous_address: '0, block_size: req_q.size, reused: 1'b0,
						status: ST_OK};
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			next_q      <= BASE_ADDRESS;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			count_q     <= count_d;
			next_q      <= next_d;
			out_valid_q <= out_load | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		base_q <= base_d;
		rsp_q  <= rsp_d;
		if (out_load) begin
			out_q <= rsp_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("descriptor count beyond table size");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CNT_W'(idx_q) < count_q))
		else $error("scan index past the last descriptor");

	a_pointer_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (next_q >= $past(next_q)))
		else $error("bump pointer moved backward");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) ||
			(($past(state_q) == S_BUMP) && (count_q == $past(count_q) + CNT_W'(1))))
		else $error("descriptor count changed outside an append");

endmodule

FILE: verif/block_descriptor_allocator_tb.sv
`timescale 1ns / 100ps

module block_descriptor_allocator_tb;
	import bda_pkg::*;

	localparam int         TABLE_SLOTS  = DEF_TABLE_ENTRIES;
	localparam int         HDR          = DEF_HEADER_BYTES;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         RANDOM_ITEMS = 1250;
	localparam int         QUIET_ITEMS  = 150;
	localparam int         CYCLE_LIMIT  = 1_000_000;
	localparam int         DRAIN_CYCLES = 80;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	req_t in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	// Shadow copy of the descriptor table and bump pointer.
	logic [31:0] desc_addr [TABLE_SLOTS];
	logic [31:0] desc_size [TABLE_SLOTS];
	bit          desc_free [TABLE_SLOTS];
	int unsigned desc_count = 0;
	logic [31:0] bump_ptr   = DEF_BASE_ADDRESS;

	rsp_t        pending_responses[$];
	stim_row_t   directed_rows[$];
	rsp_t        oldest_rsp;
	logic [31:0] size_pool [6] = '{32'd0, 32'd1, 32'd8, 32'd64, 32'd100, 32'd4096};
	int          errors      = 0;
	int          cycle_count = 0;
	int          sink_stall  = 0;
	bit          quiet       = 1'b0;

	block_descriptor_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	function automatic rsp_t allocator_outcome(req_t r);
		rsp_t        p;
		bit          found;
		int          i;
		logic [32:0] span;
		p = '0;
		found = 1'b0;
		case (r.kind)
			KIND_ALLOC: begin
				for (i = 0; i < desc_count; i++) begin
					if (!found && desc_free[i] && desc_size[i] == r.size) begin
						found = 1'b1;
						desc_free[i] = 1'b0;
						p.result_handle = i[5:0];
						p.data_address = desc_addr[i];
						p.block_size = r.size;
						p.reused = 1'b1;
					end
				end
				if (!found) begin
					span = {1'b0, bump_ptr} + 33'(HDR) + {1'b0, r.size};
					if (desc_count >= TABLE_SLOTS) begin
						p.status = ST_FULL;
					end else if (span[32]) begin
						p.status = ST_OVERFLOW;
					end else begin
						i = desc_count;
						desc_addr[i] = bump_ptr + 32'(HDR);
						desc_size[i] = r.size;
						desc_free[i] = 1'b0;
						desc_count = desc_count + 1;
						bump_ptr = span[31:0];
						p.result_handle = i[5:0];
						p.data_address = desc_addr[i];
						p.block_size = r.size;
					end
				end
			end
			KIND_FREE: begin
				p.result_handle = r.handle;
				if (r.handle >= desc_count) begin
					p.status = ST_BAD_HANDLE;
				end else begin
					desc_free[r.handle] = 1'b1;
					p.data_address = desc_addr[r.handle];
					p.block_size = desc_size[r.handle];
				end
			end
			KIND_REALLOC: begin
				p.result_handle = r.handle;
				span = {1'b0, bump_ptr} + {1'b0, r.size};
				if (r.handle >= desc_count) begin
					p.status = ST_BAD_HANDLE;
				end else if (span[32]) begin
					p.status = ST_OVERFLOW;
				end else begin
					// The entry moves to the bump pointer with no header and keeps its free mark.
					p.previous_address = desc_addr[r.handle];
					desc_addr[r.handle] = bump_ptr;
					desc_size[r.handle] = r.size;
					bump_ptr = span[31:0];
					p.data_address = desc_addr[r.handle];
					p.block_size = r.size;
				end
			end
			default: begin
				p.status = ST_BAD_HANDLE;
			end
		endcase
		return p;
	endfunction

	function automatic void add_row(logic [1:0] kind, logic [31:0] size, logic [5:0] handle,
			bit typed = 1'b0, logic [5:0] h = '0, logic [31:0] addr = '0,
			logic [31:0] prev = '0, logic [31:0] sz = '0, logic reused = 1'b0,
			logic [1:0] st = ST_OK);
		stim_row_t row;
		row.req = {kind, size, handle};
		row.typed = typed;
		row.want = {h, addr, prev, sz, reused, st};
		directed_rows.push_back(row);
	endfunction

	task automatic send_item(req_t r, bit typed, rsp_t want);
		rsp_t predicted;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = allocator_outcome(r);
		pending_responses.push_back(typed ? want : predicted);
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain_responses();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (sink_stall > 0) begin
			out_ready <= 1'b0;
			sink_stall = sink_stall - 1;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0)
				sink_stall = $urandom_range(1, 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: result with nothing expected, got handle=%0d addr=%h status=%0d",
					$time, out_data.result_handle, out_data.data_address, out_data.status);
				errors = errors + 1;
			end else begin
				oldest_rsp = pending_responses.pop_front();
				if (out_data.result_handle !== oldest_rsp.result_handle
						|| out_data.data_address !== oldest_rsp.data_address
						|| out_data.previous_address !== oldest_rsp.previous_address
						|| out_data.block_size !== oldest_rsp.block_size
						|| out_data.reused !== oldest_rsp.reused
						|| out_data.status !== oldest_rsp.status) begin
					$display("%0t: expected h=%0d a=%h p=%h s=%h r=%b st=%0d, got h=%0d a=%h p=%h s=%h r=%b st=%0d",
						$time, oldest_rsp.result_handle, oldest_rsp.data_address,
						oldest_rsp.previous_address, oldest_rsp.block_size, oldest_rsp.reused,
						oldest_rsp.status, out_data.result_handle, out_data.data_address,
						out_data.previous_address, out_data.block_size, out_data.reused,
						out_data.status);
					errors = errors + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req_t r;
		int   n;
		int   roll;
		int   pick;

		// Empty table: every handle is bad, and the unused kind reports a bad handle too.
		add_row(KIND_FREE, 32'd0, 6'd0, 1, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_BAD_HANDLE);
		add_row(KIND_REALLOC, 32'd5, 6'd63, 1, 6'd63, 32'd0, 32'd0, 32'd0, 1'b0, ST_BAD_HANDLE);
		add_row(KIND_UNUSED, 32'hFFFF_FFFF, 6'h2A, 1, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0,
			ST_BAD_HANDLE);
		add_row(KIND_ALLOC, 32'hFFFF_FFFF, 6'd0, 1, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_OVERFLOW);
		add_row(KIND_ALLOC, 32'd0, 6'd63, 1, 6'd0, 32'h0001_0010, 32'd0, 32'd0, 1'b0, ST_OK);
		add_row(KIND_ALLOC, 32'd100, 6'd0, 1, 6'd1, 32'h0001_0020, 32'd0, 32'd100, 1'b0, ST_OK);
		add_row(KIND_ALLOC, 32'd100, 6'd0);
		add_row(KIND_FREE, 32'd0, 6'd1);
		// Freeing an entry that is already free leaves it free.
		add_row(KIND_FREE, 32'd7, 6'd1);
		add_row(KIND_ALLOC, 32'd100, 6'd0);
		add_row(KIND_REALLOC, 32'h40, 6'd0);
		add_row(KIND_FREE, 32'd0, 6'd2);
		// A free entry that is moved keeps its free mark and can be reused afterwards.
		add_row(KIND_REALLOC, 32'd100, 6'd2);
		add_row(KIND_ALLOC, 32'd100, 6'd0);
		add_row(KIND_REALLOC, 32'hFFFF_FFFF, 6'd1, 1, 6'd1, 32'd0, 32'd0, 32'd0, 1'b0,
			ST_OVERFLOW);
		add_row(KIND_FREE, 32'd0, 6'd3, 1, 6'd3, 32'd0, 32'd0, 32'd0, 1'b0, ST_BAD_HANDLE);
		add_row(KIND_ALLOC, 32'd0, 6'd0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if ($urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 12));
			send_item(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
		end
		drain_responses();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
			if (!quiet && $urandom_range(0, 4) == 0)
				hold_off($urandom_range(1, 12));
			if (!quiet && $urandom_range(0, 299) == 0)
				drain_responses();
			roll = $urandom_range(0, 99);
			r.kind = roll < 45 ? KIND_ALLOC : roll < 75 ? KIND_FREE :
				roll < 95 ? KIND_REALLOC : KIND_UNUSED;
			// Sizes come mostly from a small pool so that freed entries get reused.
			pick = $urandom_range(0, 9);
			if (pick < 6)
				r.size = size_pool[$urandom_range(0, 5)];
			else if (pick < 8)
				r.size = $urandom_range(0, 65535);
			else if (pick == 8)
				r.size = $urandom_range(65536, 1 << 20);
			else
				r.size = {16'hFFFF, 16'($urandom)};
			if (desc_count != 0 && $urandom_range(0, 7) != 0)
				r.handle = 6'($urandom_range(0, desc_count - 1));
			else
				r.handle = 6'($urandom_range(0, 63));
			send_item(r, 1'b0, '0);
		end

		// Run the bump pointer up to the top of the address space, then one byte past it.
		send_item({KIND_REALLOC, 32'hFFFF_FFFF - bump_ptr, 6'd0}, 1'b0, '0);
		send_item({KIND_REALLOC, 32'd1, 6'd0}, 1'b0, '0);
		send_item({KIND_REALLOC, 32'd0, 6'd0}, 1'b0, '0);
		send_item({KIND_ALLOC, 32'd0, 6'd0}, 1'b0, '0);

		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
design/bda_pkg.sv
design/bda_ram.sv
design/bda_alu.sv
design/block_descriptor_allocator.sv
verif/block_descriptor_allocator_tb.sv
